### hw/rtl/dcem_pkg.sv
// dc power and energy meter: shared types, register indexes and fixed widths
// no dependencies; imported by dc_power_energy_meter
`default_nettype none

package dcem_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int OFFSET_W   = 17;
    localparam int SCALE_W    = 24;
    localparam int VALUE_W    = 21;
    localparam int POWER_W    = 42;
    localparam int ENERGY_W   = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // serial multiplier: multiplicand width and multiplier bits per pass
    localparam int MC_W        = POWER_W;
    localparam int MUL_STEPS   = 32;
    localparam int STEP_W      = 6;
    localparam int SCALE_SHIFT = 20;
    // accumulator bits that land in a scaled value after the shift
    localparam int SCL_HI_W    = VALUE_W - (MUL_STEPS - SCALE_SHIFT);
    localparam int PWR_HI_W    = POWER_W - MUL_STEPS;
    localparam int NRG_HI_W    = ENERGY_W - MUL_STEPS;

    localparam logic [VALUE_W-1:0]  VALUE_MAX  = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL_MS = 3'd4;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET    = 24'd65536;
    localparam logic [TIME_W-1:0]  INTERVAL_RESET = 32'd1000;

    // item operation codes
    localparam logic OP_SAMPLE      = 1'b0;
    localparam logic OP_CLEAR_TOTAL = 1'b1;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] current_pos_sample;
        logic [SAMPLE_W-1:0] current_neg_sample;
        logic [SAMPLE_W-1:0] voltage_pos_sample;
        logic [SAMPLE_W-1:0] voltage_neg_sample;
        logic [TIME_W-1:0]   now_ms;
    } sample_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  current_value;
        logic [VALUE_W-1:0]  voltage_value;
        logic [POWER_W-1:0]  power_value;
        logic [ENERGY_W-1:0] total_energy;
        logic                committed;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RAW,
        ST_MUL,
        ST_POST,
        ST_PEND,
        ST_TOTAL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MOP_CUR,
        MOP_VOLT,
        MOP_PWR,
        MOP_NRG
    } mul_op_t;

endpackage

`default_nettype wire

### hw/rtl/dc_power_energy_meter.sv
// dc power and energy meter, top level: sample sums, serial divider and multiplier, energy
// depends on dcem_pkg
`default_nettype none

// Each sample beat adds the pos-minus-neg differences of the current and voltage ADC
// pairs into two signed sums; it gives no result unless it completes a measurement of
// SAMPLES_PER_MEASURE sets. The completing beat starts a sequencer built around two
// bit-serial units: a restoring divider that forms each Q12.4 average one quotient bit
// per cycle, and one shift-add multiplier that takes one multiplier bit per cycle and
// is shared by the two scale products, the power product and the power-times-elapsed-ms
// product. The dividend width DVD is the sum width + 4 (21 at the default parameters).
// The sample port stalls until the result is handed to the output register, and a
// clear-total beat also passes through the output state. The output register holds
// a finished result while new samples are taken; a further result waits only if that
// register is still full. Elapsed time is measured since the previous measurement, and
// energy and total saturate at 2^64-1. Configuration writes are accepted in every cycle
// and must only be issued while the block is idle.
module dc_power_energy_meter #(
    parameter int SAMPLES_PER_MEASURE = 16,
    parameter int ADC_BITS            = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // sample channel
    input  wire logic                              sample_valid,
    output      logic                              sample_stall,
    input  wire dcem_pkg::sample_t                 sample_data,
    // result channel
    output      logic                              result_valid,
    input  wire logic                              result_stall,
    output      dcem_pkg::result_t                 result_data,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [dcem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dcem_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import dcem_pkg::*;

    // effective sample width: inputs are masked down to the converter resolution
    localparam int SMP_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam int CNT_W    = (SAMPLES_PER_MEASURE > 1) ? $clog2(SAMPLES_PER_MEASURE) : 1;
    localparam int SUM_W    = SMP_BITS + 1 + $clog2(SAMPLES_PER_MEASURE);
    // dividend is |sum| * 16
    localparam int DVD_W    = SUM_W + 4;
    localparam int REM_W    = $clog2(SAMPLES_PER_MEASURE) + 2;
    localparam int RAW_W    = ((DVD_W + 1 > OFFSET_W) ? DVD_W + 1 : OFFSET_W) + 1;

    localparam logic [CNT_W-1:0]  LAST_COUNT = CNT_W'(SAMPLES_PER_MEASURE - 1);
    localparam logic [REM_W-1:0]  DIVISOR    = REM_W'(SAMPLES_PER_MEASURE);
    localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DVD_W - 1);
    localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(MUL_STEPS - 1);

    // magnitude of a signed sum, shifted into Q17.4 at the default parameters
    function automatic logic [DVD_W-1:0] dividend_of(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] mag;
        mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        return {mag, 4'b0000};
    endfunction

    // configuration registers
    logic signed [OFFSET_W-1:0] current_offset_reg;
    logic [SCALE_W-1:0]         current_scale_reg;
    logic signed [OFFSET_W-1:0] voltage_offset_reg;
    logic [SCALE_W-1:0]         voltage_scale_reg;
    logic [TIME_W-1:0]          update_interval_reg;

    // sequencer and measurement state
    state_t                     state_reg, state_next;
    mul_op_t                    mop_reg, mop_next;
    logic                       ch_reg, ch_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    c_sum_reg, c_sum_next;
    logic signed [SUM_W-1:0]    v_sum_reg, v_sum_next;
    logic [ENERGY_W-1:0]        pending_reg, pending_next;
    logic [ENERGY_W-1:0]        total_reg, total_next;
    logic [TIME_W-1:0]          last_commit_reg, last_commit_next;
    logic [TIME_W-1:0]          last_measure_reg, last_measure_next;
    logic                       result_valid_reg, result_valid_next;

    // serial datapath and staging
    logic [DVD_W-1:0]           dvd_reg, dvd_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic                       neg_reg, neg_next;
    logic [MC_W-1:0]            mcand_reg, mcand_next;
    logic [MC_W:0]              acc_reg, acc_next;
    logic [MUL_STEPS-1:0]       mplr_reg, mplr_next;
    logic [VALUE_W-1:0]         cur_reg, cur_next;
    logic [VALUE_W-1:0]         volt_reg, volt_next;
    logic [POWER_W-1:0]         power_reg, power_next;
    logic [ENERGY_W-1:0]        energy_reg, energy_next;
    logic [TIME_W-1:0]          now_reg, now_next;
    logic                       commit_reg, commit_next;
    result_t                    result_reg, result_next;

    // combinational helpers
    logic                       sample_take;
    logic                       result_free;
    logic                       step_done;
    logic                       last_sample;
    logic                       commit_due;
    logic [SMP_BITS-1:0]        cp, cn, vp, vn;
    logic signed [SMP_BITS:0]   c_diff, v_diff;
    logic signed [SUM_W-1:0]    c_sum_add, v_sum_add;
    logic [REM_W-1:0]           div_trial;
    logic                       div_ge;
    logic signed [RAW_W-1:0]    raw_q, raw_avg, raw_off, raw_val;
    logic                       raw_pos;
    logic [MC_W:0]              mul_sum;
    logic [VALUE_W-1:0]         scaled;
    logic [POWER_W-1:0]         power_prod;
    logic [ENERGY_W-1:0]        energy_prod;
    logic [ENERGY_W:0]          pend_sum, tot_sum;
    logic [ENERGY_W-1:0]        pend_sat;
    logic [TIME_W-1:0]          dt_ms;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_take  = sample_valid && (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;
    // output register can take a new result when empty or emptying this cycle
    assign result_free  = !result_valid_reg || !result_stall;
    assign step_done    = (step_reg == '0);

    // sample differences, masked to the converter resolution
    assign cp     = sample_data.current_pos_sample[SMP_BITS-1:0];
    assign cn     = sample_data.current_neg_sample[SMP_BITS-1:0];
    assign vp     = sample_data.voltage_pos_sample[SMP_BITS-1:0];
    assign vn     = sample_data.voltage_neg_sample[SMP_BITS-1:0];
    assign c_diff = $signed({1'b0, cp}) - $signed({1'b0, cn});
    assign v_diff = $signed({1'b0, vp}) - $signed({1'b0, vn});
    assign c_sum_add   = c_sum_reg + SUM_W'(c_diff);
    assign v_sum_add   = v_sum_reg + SUM_W'(v_diff);
    assign last_sample = (count_reg == LAST_COUNT);

    // restoring divider step by the sample count
    assign div_trial = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign div_ge    = (div_trial >= DIVISOR);

    // average minus offset; zero or below gives a zero value
    assign raw_q   = $signed({{(RAW_W - DVD_W){1'b0}}, dvd_reg});
    assign raw_avg = neg_reg ? -raw_q : raw_q;
    assign raw_off = ch_reg ? RAW_W'(voltage_offset_reg) : RAW_W'(current_offset_reg);
    assign raw_val = raw_avg - raw_off;
    assign raw_pos = !raw_val[RAW_W-1] && (raw_val != '0);

    // shift-add step: product low bits shift into the multiplier register
    assign mul_sum = {1'b0, acc_reg[MC_W-1:0]} + {1'b0, (mplr_reg[0] ? mcand_reg : '0)};

    // finished products
    assign scaled      = (acc_reg[MC_W:SCL_HI_W] != '0) ? VALUE_MAX
                       : {acc_reg[SCL_HI_W-1:0], mplr_reg[MUL_STEPS-1:SCALE_SHIFT]};
    assign power_prod  = {acc_reg[PWR_HI_W-1:0], mplr_reg};
    assign energy_prod = (acc_reg[MC_W:NRG_HI_W] != '0) ? ENERGY_MAX
                       : {acc_reg[NRG_HI_W-1:0], mplr_reg};

    assign dt_ms      = now_reg - last_measure_reg;
    assign commit_due = ((now_reg - last_commit_reg) >= update_interval_reg);
    assign pend_sum   = {1'b0, pending_reg} + {1'b0, energy_reg};
    assign pend_sat   = pend_sum[ENERGY_W] ? ENERGY_MAX : pend_sum[ENERGY_W-1:0];
    assign tot_sum    = {1'b0, total_reg} + {1'b0, pending_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_take)
                begin
                    if (sample_data.op == OP_CLEAR_TOTAL)
                        state_next = ST_OUT;
                    else if (last_sample)
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_done)
                    state_next = ST_RAW;
            end
            ST_RAW:
                state_next = ST_MUL;
            ST_MUL:
            begin
                if (step_done)
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                case (mop_reg)
                    MOP_CUR:  state_next = ST_DIV;
                    MOP_NRG:  state_next = ST_PEND;
                    default:  state_next = ST_MUL;
                endcase
            end
            ST_PEND:
                state_next = commit_due ? ST_TOTAL : ST_OUT;
            ST_TOTAL:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (result_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mop_next          = mop_reg;
        ch_next           = ch_reg;
        step_next         = step_reg;
        count_next        = count_reg;
        c_sum_next        = c_sum_reg;
        v_sum_next        = v_sum_reg;
        pending_next      = pending_reg;
        total_next        = total_reg;
        last_commit_next  = last_commit_reg;
        last_measure_next = last_measure_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        neg_next          = neg_reg;
        mcand_next        = mcand_reg;
        acc_next          = acc_reg;
        mplr_next         = mplr_reg;
        cur_next          = cur_reg;
        volt_next         = volt_reg;
        power_next        = power_reg;
        energy_next       = energy_reg;
        now_next          = now_reg;
        commit_next       = commit_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_take)
                begin
                    if (sample_data.op == OP_CLEAR_TOTAL)
                    begin
                        total_next  = '0;
                        cur_next    = '0;
                        volt_next   = '0;
                        power_next  = '0;
                        commit_next = 1'b1;
                    end
                    else
                    begin
                        c_sum_next = c_sum_add;
                        v_sum_next = v_sum_add;
                        if (last_sample)
                        begin
                            // measurement complete: start the current average
                            count_next = '0;
                            now_next   = sample_data.now_ms;
                            dvd_next   = dividend_of(c_sum_add);
                            neg_next   = c_sum_add[SUM_W-1];
                            rem_next   = '0;
                            ch_next    = 1'b0;
                            step_next  = DIV_LAST;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = div_ge ? (div_trial - DIVISOR) : div_trial;
                dvd_next  = {dvd_reg[DVD_W-2:0], div_ge};
                step_next = step_reg - STEP_W'(1);
            end
            ST_RAW:
            begin
                mcand_next = raw_pos ? MC_W'(raw_val[RAW_W-2:0]) : '0;
                mplr_next  = MUL_STEPS'(ch_reg ? voltage_scale_reg : current_scale_reg);
                acc_next   = '0;
                mop_next   = ch_reg ? MOP_VOLT : MOP_CUR;
                step_next  = MUL_LAST;
            end
            ST_MUL:
            begin
                acc_next  = {1'b0, mul_sum[MC_W:1]};
                mplr_next = {mul_sum[0], mplr_reg[MUL_STEPS-1:1]};
                step_next = step_reg - STEP_W'(1);
            end
            ST_POST:
            begin
                case (mop_reg)
                    MOP_CUR:
                    begin
                        // current done, start the voltage average
                        cur_next  = scaled;
                        dvd_next  = dividend_of(v_sum_reg);
                        neg_next  = v_sum_reg[SUM_W-1];
                        rem_next  = '0;
                        ch_next   = 1'b1;
                        step_next = DIV_LAST;
                    end
                    MOP_VOLT:
                    begin
                        volt_next  = scaled;
                        mcand_next = MC_W'(cur_reg);
                        mplr_next  = MUL_STEPS'(scaled);
                        acc_next   = '0;
                        mop_next   = MOP_PWR;
                        step_next  = MUL_LAST;
                    end
                    MOP_PWR:
                    begin
                        power_next = power_prod;
                        mcand_next = MC_W'(power_prod);
                        mplr_next  = dt_ms;
                        acc_next   = '0;
                        mop_next   = MOP_NRG;
                        step_next  = MUL_LAST;
                    end
                    default:
                        energy_next = energy_prod;
                endcase
            end
            ST_PEND:
            begin
                pending_next      = pend_sat;
                last_measure_next = now_reg;
                c_sum_next        = '0;
                v_sum_next        = '0;
                commit_next       = commit_due;
            end
            ST_TOTAL:
            begin
                total_next       = tot_sum[ENERGY_W] ? ENERGY_MAX : tot_sum[ENERGY_W-1:0];
                pending_next     = '0;
                last_commit_next = now_reg;
            end
            ST_OUT:
            begin
                if (result_free)
                begin
                    result_next.current_value = cur_reg;
                    result_next.voltage_value = volt_reg;
                    result_next.power_value   = power_reg;
                    result_next.total_energy  = total_reg;
                    result_next.committed     = commit_reg;
                    result_valid_next         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            c_sum_reg        <= '0;
            v_sum_reg        <= '0;
            pending_reg      <= '0;
            total_reg        <= '0;
            last_commit_reg  <= '0;
            last_measure_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            c_sum_reg        <= c_sum_next;
            v_sum_reg        <= v_sum_next;
            pending_reg      <= pending_next;
            total_reg        <= total_next;
            last_commit_reg  <= last_commit_next;
            last_measure_reg <= last_measure_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // serial datapath and staging, no reset needed
    always_ff @(posedge clk)
    begin
        mop_reg    <= mop_next;
        ch_reg     <= ch_next;
        step_reg   <= step_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplr_reg   <= mplr_next;
        cur_reg    <= cur_next;
        volt_reg   <= volt_next;
        power_reg  <= power_next;
        energy_reg <= energy_next;
        now_reg    <= now_next;
        commit_reg <= commit_next;
        result_reg <= result_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_offset_reg  <= '0;
            current_scale_reg   <= SCALE_RESET;
            voltage_offset_reg  <= '0;
            voltage_scale_reg   <= SCALE_RESET;
            update_interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CURRENT_OFFSET:     current_offset_reg  <= cfg_wdata[OFFSET_W-1:0];
                REG_CURRENT_SCALE:      current_scale_reg   <= cfg_wdata[SCALE_W-1:0];
                REG_VOLTAGE_OFFSET:     voltage_offset_reg  <= cfg_wdata[OFFSET_W-1:0];
                REG_VOLTAGE_SCALE:      voltage_scale_reg   <= cfg_wdata[SCALE_W-1:0];
                REG_UPDATE_INTERVAL_MS: update_interval_reg <= cfg_wdata[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### verif/dc_power_energy_meter_checker.sv
`timescale 1ns / 100ps
// energy meter checker: follows the sample, config and result channels, keeps its own
// model of the meter and compares every result beat; depends on dcem_pkg
module dc_power_energy_meter_checker
    import dcem_pkg::*;
#(
    parameter int SAMPLES_PER_MEASURE = 16,
    parameter int ADC_BITS            = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    input  wire logic                  sample_stall,
    input  wire sample_t               sample_data,
    input  wire logic                  result_valid,
    input  wire logic                  result_stall,
    input  wire result_t               result_data,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         mismatch_count,
    output int                         readings_waiting
);

    localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

    result_t expected_readings[$];

    int                  sets_gathered;
    longint              current_sum;
    longint              voltage_sum;
    logic [ENERGY_W-1:0] pending_energy;
    logic [ENERGY_W-1:0] committed_total;
    logic [TIME_W-1:0]   last_commit_ms;
    logic [TIME_W-1:0]   last_measure_ms;

    longint              current_offset;
    longint              voltage_offset;
    logic [SCALE_W-1:0]  current_scale;
    logic [SCALE_W-1:0]  voltage_scale;
    logic [TIME_W-1:0]   update_interval_ms;

    function automatic longint offset_of(logic [CFG_DATA_W-1:0] wdata);
        logic [OFFSET_W-1:0] bits;
        bits = wdata[OFFSET_W-1:0];
        return longint'(signed'(bits));
    endfunction

    function automatic logic [VALUE_W-1:0] scaled_value(longint sum, longint offset,
                                                        logic [SCALE_W-1:0] scale);
        longint      average;
        longint      raw;
        logic [63:0] magnitude;
        logic [63:0] product;
        average = (sum * 16) / SAMPLES_PER_MEASURE;
        raw = average - offset;
        if (raw <= 0)
            return '0;
        magnitude = raw;
        product = (magnitude * scale) >> SCALE_SHIFT;
        if (product > VALUE_MAX)
            return VALUE_MAX;
        return product[VALUE_W-1:0];
    endfunction

    function automatic logic [ENERGY_W-1:0] add_saturating(logic [ENERGY_W-1:0] a,
                                                          logic [ENERGY_W-1:0] b);
        logic [ENERGY_W:0] sum;
        sum = a + b;
        return sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
    endfunction

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_reading(input result_t got);
        result_t want;
        if (expected_readings.size() == 0)
        begin
            $display("%0t: result beat with nothing expected, expected none actual %h",
                     $time, got);
            mismatch_count++;
        end
        else
        begin
            want = expected_readings.pop_front();
            compare_field("current_value", want.current_value, got.current_value);
            compare_field("voltage_value", want.voltage_value, got.voltage_value);
            compare_field("power_value", want.power_value, got.power_value);
            compare_field("total_energy", want.total_energy, got.total_energy);
            compare_field("committed", want.committed, got.committed);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] wdata);
        case (index)
            REG_CURRENT_OFFSET:     current_offset = offset_of(wdata);
            REG_CURRENT_SCALE:      current_scale = wdata[SCALE_W-1:0];
            REG_VOLTAGE_OFFSET:     voltage_offset = offset_of(wdata);
            REG_VOLTAGE_SCALE:      voltage_scale = wdata[SCALE_W-1:0];
            REG_UPDATE_INTERVAL_MS: update_interval_ms = wdata[TIME_W-1:0];
            default:                ;
        endcase
    endtask

    task automatic take_sample(input sample_t beat);
        result_t             reading;
        logic [VALUE_W-1:0]  cur;
        logic [VALUE_W-1:0]  volt;
        logic [63:0]         power;
        logic [TIME_W-1:0]   dt;
        logic [TIME_W-1:0]   since_commit;
        logic [127:0]        energy_wide;
        logic [ENERGY_W-1:0] energy;
        reading = '0;
        if (beat.op == OP_CLEAR_TOTAL)
        begin
            // clear keeps sums, pending energy and times
            committed_total = '0;
            reading.committed = 1'b1;
            expected_readings.push_back(reading);
            return;
        end
        current_sum += longint'(beat.current_pos_sample & ADC_MASK)
                     - longint'(beat.current_neg_sample & ADC_MASK);
        voltage_sum += longint'(beat.voltage_pos_sample & ADC_MASK)
                     - longint'(beat.voltage_neg_sample & ADC_MASK);
        sets_gathered++;
        if (sets_gathered < SAMPLES_PER_MEASURE)
            return;

        cur = scaled_value(current_sum, current_offset, current_scale);
        volt = scaled_value(voltage_sum, voltage_offset, voltage_scale);
        power = cur * volt;
        sets_gathered = 0;
        current_sum = 0;
        voltage_sum = 0;

        // elapsed ms since the previous measurement, wrapping
        dt = beat.now_ms - last_measure_ms;
        energy_wide = power * dt;
        energy = (energy_wide[127:ENERGY_W] != '0) ? ENERGY_MAX : energy_wide[ENERGY_W-1:0];
        pending_energy = add_saturating(pending_energy, energy);
        last_measure_ms = beat.now_ms;

        since_commit = beat.now_ms - last_commit_ms;
        if (since_commit >= update_interval_ms)
        begin
            committed_total = add_saturating(committed_total, pending_energy);
            pending_energy = '0;
            last_commit_ms = beat.now_ms;
            reading.committed = 1'b1;
        end

        reading.current_value = cur;
        reading.voltage_value = volt;
        reading.power_value = power[POWER_W-1:0];
        reading.total_energy = committed_total;
        expected_readings.push_back(reading);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_readings.delete();
            mismatch_count = 0;
            sets_gathered = 0;
            current_sum = 0;
            voltage_sum = 0;
            pending_energy = '0;
            committed_total = '0;
            last_commit_ms = '0;
            last_measure_ms = '0;
            current_offset = 0;
            voltage_offset = 0;
            current_scale = SCALE_RESET;
            voltage_scale = SCALE_RESET;
            update_interval_ms = INTERVAL_RESET;
        end
        else
        begin
            // a result can never come from a sample taken at the same edge
            if (result_valid && !result_stall)
                check_reading(result_data);
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_wdata);
            if (sample_valid && !sample_stall)
                take_sample(sample_data);
        end
        readings_waiting = expected_readings.size();
    end

endmodule

### verif/dc_power_energy_meter_test.sv
`timescale 1ns / 100ps
// energy meter testbench top: clock, reset, sample and config stimulus, verdict
// depends on dcem_pkg, dc_power_energy_meter and dc_power_energy_meter_checker
module dc_power_energy_meter_test;

    import dcem_pkg::*;

    localparam int SAMPLES_PER_MEASURE = 16;
    localparam int ADC_BITS            = 12;
    // settle time before config writes, longer than one measurement runs
    localparam int SETTLE_CYCLES       = 220;
    localparam int CYCLE_LIMIT         = 400000;
    localparam int ITEM_TARGET         = 450;
    localparam int PHASE_ITEMS         = 64;
    localparam logic [SAMPLE_W-1:0] ADC_FULL = '1;

    // shape of the sample values over one measurement
    typedef enum int {
        MIX_RANDOM,
        MIX_POSITIVE,
        MIX_NEGATIVE,
        MIX_EXTREME
    } sample_mix_t;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample_data;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int                    mismatch_count;
    int                    readings_waiting;

    // stimulus bookkeeping
    bit                    calm;
    logic [TIME_W-1:0]     now_ms;
    int                    items_sent;
    int                    sets_in_measure;
    sample_mix_t           mix;
    int                    cycles = 0;

    dc_power_energy_meter #(
        .SAMPLES_PER_MEASURE(SAMPLES_PER_MEASURE),
        .ADC_BITS(ADC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_data(sample_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    dc_power_energy_meter_checker #(
        .SAMPLES_PER_MEASURE(SAMPLES_PER_MEASURE),
        .ADC_BITS(ADC_BITS)
    ) meter_checker (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_data(sample_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .mismatch_count(mismatch_count),
        .readings_waiting(readings_waiting)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, counted in clock cycles
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side back-pressure at random, 19 percent likely, none while calm
    always @(negedge clk)
        result_stall <= !calm && ($urandom_range(0, 99) < 19);

    // half of all measurements positive so that power and energy really build up
    function automatic sample_mix_t pick_mix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return MIX_POSITIVE;
        else if (r < 70)
            return MIX_RANDOM;
        else if (r < 85)
            return MIX_EXTREME;
        return MIX_NEGATIVE;
    endfunction

    // one adc reading; high_side picks the pos input of a pair
    function automatic logic [SAMPLE_W-1:0] pick_reading(sample_mix_t shape, bit high_side);
        case (shape)
            MIX_POSITIVE: return high_side ? SAMPLE_W'($urandom_range(2048, 4095))
                                           : SAMPLE_W'($urandom_range(0, 2047));
            MIX_NEGATIVE: return high_side ? SAMPLE_W'($urandom_range(0, 2047))
                                           : SAMPLE_W'($urandom_range(2048, 4095));
            MIX_EXTREME:  return $urandom_range(0, 1) ? ADC_FULL : '0;
            default:      return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // drive one sample beat and hold it until taken; starts and ends at a falling edge
    task automatic send_beat(input logic op,
                             input logic [SAMPLE_W-1:0] cur_pos,
                             input logic [SAMPLE_W-1:0] cur_neg,
                             input logic [SAMPLE_W-1:0] volt_pos,
                             input logic [SAMPLE_W-1:0] volt_neg,
                             input logic [TIME_W-1:0] stamp);
        sample_t beat;
        beat.op = op;
        beat.current_pos_sample = cur_pos;
        beat.current_neg_sample = cur_neg;
        beat.voltage_pos_sample = volt_pos;
        beat.voltage_neg_sample = volt_neg;
        beat.now_ms = stamp;
        // random idle cycles ahead of the beat
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_data <= beat;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
        // track items sent and the position within a measurement
        items_sent++;
        if (op != OP_CLEAR_TOTAL)
        begin
            sets_in_measure++;
            if (sets_in_measure == SAMPLES_PER_MEASURE)
                sets_in_measure = 0;
        end
    endtask

    // free-running ms clock: small steps, some repeats, rare big jumps that wrap
    task automatic tick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            now_ms += $urandom;
        else if (r >= 15)
            now_ms += $urandom_range(1, 40);
    endtask

    task automatic send_random_set(input sample_mix_t shape);
        tick_time();
        send_beat(OP_SAMPLE, pick_reading(shape, 1'b1), pick_reading(shape, 1'b0),
                  pick_reading(shape, 1'b1), pick_reading(shape, 1'b0), now_ms);
    endtask

    // clear beat with junk in the sample fields, which the block ignores
    task automatic send_clear();
        send_beat(OP_CLEAR_TOTAL, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                  SAMPLE_W'($urandom), SAMPLE_W'($urandom), $urandom);
    endtask

    // full measurements with random content, broken now and then by a clear
    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (sets_in_measure == 0)
                mix = pick_mix();
            if ($urandom_range(0, 99) < 4)
                send_clear();
            else
                send_random_set(mix);
        end
    endtask

    // stop sending, let every result drain, then give the sequencer time to go idle
    task automatic quiesce();
        sample_valid <= 1'b0;
        while (readings_waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // one config write beat; leaves valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] wdata);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= wdata;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_meter(input logic [CFG_DATA_W-1:0] cur_offset,
                                 input logic [CFG_DATA_W-1:0] cur_scale,
                                 input logic [CFG_DATA_W-1:0] volt_offset,
                                 input logic [CFG_DATA_W-1:0] volt_scale,
                                 input logic [CFG_DATA_W-1:0] interval_ms);
        write_reg(REG_CURRENT_OFFSET, cur_offset);
        write_reg(REG_CURRENT_SCALE, cur_scale);
        write_reg(REG_VOLTAGE_OFFSET, volt_offset);
        write_reg(REG_VOLTAGE_SCALE, volt_scale);
        write_reg(REG_UPDATE_INTERVAL_MS, interval_ms);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        // every input known from time zero
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample_data = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        calm = 1'b0;
        now_ms = '0;
        items_sent = 0;
        sets_in_measure = 0;
        mix = MIX_POSITIVE;

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: clear with nothing stored, then one measurement at reset settings
        send_beat(OP_CLEAR_TOTAL, ADC_FULL, ADC_FULL, '0, '0, '0);
        for (int i = 0; i < SAMPLES_PER_MEASURE; i++)
        begin
            // full-scale current pairs both ways round, voltage full scale but reversed in the last set;
            // the first measurement counts its elapsed time from zero and commits
            send_beat(OP_SAMPLE,
                      (i < 12) ? ADC_FULL : '0,
                      (i < 12) ? '0 : ADC_FULL,
                      (i == 15) ? '0 : ADC_FULL,
                      (i == 15) ? ADC_FULL : '0,
                      (i == 15) ? TIME_W'(1500) : TIME_W'(100 + i));
        end
        now_ms = 1500;
        // clear right after a commit
        send_beat(OP_CLEAR_TOTAL, '0, '0, ADC_FULL, ADC_FULL, now_ms);

        // random phases, each under its own register setting
        for (int phase = 0; items_sent < ITEM_TARGET; phase++)
        begin
            if (phase > 0)
                quiesce();
            case (phase)
                0:  ;
                1:  program_meter(32'hFFFF_0000, 32'h00FF_FFFF, 32'hFFFF_0000,
                                  32'h00FF_FFFF, 32'h0000_0000);
                2:  program_meter(32'h0000_FFFF, 32'h0000_0000, 32'h0000_FFFF,
                                  32'h0000_0000, 32'hFFFF_FFFF);
                3:  program_meter($urandom_range(0, 131071) - 65536,
                                  $urandom_range(0, 24'hFF_FFFF),
                                  $urandom_range(0, 131071) - 65536,
                                  $urandom_range(0, 24'hFF_FFFF), 32'd1);
                default:
                    program_meter($urandom_range(0, 3200) - 1600,
                                  $urandom_range(0, 24'hFF_FFFF),
                                  $urandom_range(0, 3200) - 1600,
                                  $urandom_range(0, 24'hFF_FFFF),
                                  ($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(1, 3000));
            endcase
            // a long stretch with no idling on either side
            calm = (phase == 3);
            // max gain, commit every measurement, huge elapsed time: energy saturates
            if (phase == 1)
                now_ms += 32'hC000_0000;
            run_random(PHASE_ITEMS);
        end
        calm = 1'b0;

        // drain whatever is still owed, then watch for strays
        sample_valid <= 1'b0;
        while (readings_waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        if (mismatch_count == 0 && readings_waiting == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/dcem_pkg.sv
hw/rtl/dc_power_energy_meter.sv
verif/dc_power_energy_meter_checker.sv
verif/dc_power_energy_meter_test.sv
